>>> design/assert_macros.svh
// Assertion helpers for the clock RTL.
// ASSERT_IMP: same-cycle implication under the clock, off while in reset.
// ASSERT_NXT: next-cycle implication under the clock, off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/tsicc_pkg.sv
package tsicc_pkg;

    localparam int TIME_W  = 32;
    localparam int CMD_W   = 4;
    localparam int MST_W   = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [TIME_W-1:0] TIME_MAX    = '1;
    localparam logic [TIME_W-1:0] SERIAL_HALF = 32'h8000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_NEW_GAME  = 4'd0,
        CMD_START     = 4'd1,
        CMD_PAUSE     = 4'd2,
        CMD_RESUME    = 4'd3,
        CMD_UPDATE    = 4'd4,
        CMD_MOVE      = 4'd5,
        CMD_SET_ONE   = 4'd6,
        CMD_SYNC_BOTH = 4'd7,
        CMD_ADD_TIME  = 4'd8,
        CMD_QUERY     = 4'd9
    } cmd_t;

    typedef enum logic [MST_W-1:0] {
        MS_APPLIED     = 3'd0,
        MS_DISABLED    = 3'd1,
        MS_NOT_STARTED = 3'd2,
        MS_FLAGGED     = 3'd3,
        MS_PAUSED      = 3'd4,
        MS_WRONG_SIDE  = 3'd5
    } mst_t;

    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_INITIAL   = 2'd1,
        REG_INCREMENT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic              enabled;
        logic [TIME_W-1:0] initial_ms;
        logic [TIME_W-1:0] increment_ms;
    } tsicc_cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              side;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] value_a;
        logic [TIME_W-1:0] value_b;
        logic [TIME_W-1:0] event_id;
    } tsicc_req_t;

    typedef struct packed {
        logic [1:0][TIME_W-1:0] side_time;
        logic                   running_side;
        logic [TIME_W-1:0]      anchor;
        logic                   started;
        logic                   paused;
        logic                   flag;
        logic                   flag_who;
        logic                   event_seen;
        logic [TIME_W-1:0]      event_last;
    } tsicc_state_t;

    typedef struct packed {
        logic              accepted;
        mst_t              move_status;
        logic [TIME_W-1:0] white_ms;
        logic [TIME_W-1:0] black_ms;
        logic              active_side;
        logic              is_started;
        logic              is_paused;
        logic              has_flag;
        logic              flag_side;
        logic              has_event;
        logic [TIME_W-1:0] last_event;
    } tsicc_result_t;

    // Fresh game: both sides loaded, everything else cleared.
    function automatic tsicc_state_t new_game_state(input logic [TIME_W-1:0] init_ms);
        tsicc_state_t s;
        s.side_time[0] = init_ms;
        s.side_time[1] = init_ms;
        s.running_side = 1'b0;
        s.anchor       = '0;
        s.started      = 1'b0;
        s.paused       = 1'b0;
        s.flag         = 1'b0;
        s.flag_who     = 1'b0;
        s.event_seen   = 1'b0;
        s.event_last   = '0;
        return s;
    endfunction

endpackage

>>> design/tsicc_step.sv
module tsicc_step (
    input  tsicc_pkg::tsicc_cfg_t    cfg,
    input  tsicc_pkg::tsicc_state_t  st,
    input  tsicc_pkg::tsicc_req_t    req,
    output tsicc_pkg::tsicc_state_t  nx,
    output tsicc_pkg::tsicc_result_t res
);
    import tsicc_pkg::*;

    // Add with clamp at the top of the time range.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Re-derive the flag after times were overwritten; re-anchor at now.
    function automatic tsicc_state_t reconcile(input tsicc_state_t s,
                                               input logic [TIME_W-1:0] now);
        tsicc_state_t r;
        r      = s;
        r.flag = 1'b0;
        if (s.started) begin
            if (s.side_time[s.running_side] == '0) begin
                r.flag     = 1'b1;
                r.flag_who = s.running_side;
            end else if (s.side_time[~s.running_side] == '0) begin
                r.flag     = 1'b1;
                r.flag_who = ~s.running_side;
            end
        end
        if (r.flag) begin
            r.paused = 1'b0;
        end
        r.anchor = now;
        return r;
    endfunction

    logic              running;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] t_rs;
    logic              ch_zero;
    logic [TIME_W-1:0] ch_rem;
    tsicc_state_t      chg;
    logic [TIME_W-1:0] id_gap;
    logic              add_ok;
    logic              run_n;
    logic [TIME_W-1:0] proj_rs;
    logic              acc;
    mst_t              mst;

    always_comb
    begin
        running = cfg.enabled && st.started && !st.paused && !st.flag;
        elapsed = req.now_ms - st.anchor;
        t_rs    = st.side_time[st.running_side];
        ch_zero = (elapsed >= t_rs);
        ch_rem  = t_rs - elapsed;

        // State as it stands after charging the running side up to now.
        chg = st;
        if (running) begin
            if (ch_zero) begin
                chg.side_time[st.running_side] = '0;
                chg.flag                       = 1'b1;
                chg.flag_who                   = st.running_side;
                chg.paused                     = 1'b0;
            end else begin
                chg.side_time[st.running_side] = ch_rem;
                chg.anchor                     = req.now_ms;
            end
        end

        id_gap = req.event_id - st.event_last;
        add_ok = cfg.enabled && st.started && !st.flag &&
                 !(st.event_seen && ((id_gap == '0) || (id_gap >= SERIAL_HALF)));

        nx  = st;
        acc = 1'b0;
        mst = MS_APPLIED;

        case (req.cmd)
            CMD_NEW_GAME:
            begin
                nx  = new_game_state(cfg.initial_ms);
                acc = 1'b1;
            end
            CMD_START:
            begin
                if (cfg.enabled && !st.started) begin
                    nx.running_side = 1'b0;
                    nx.anchor       = req.now_ms;
                    nx.started      = 1'b1;
                    nx.paused       = 1'b0;
                    nx.flag         = 1'b0;
                    acc             = 1'b1;
                end
            end
            CMD_PAUSE:
            begin
                if (running) begin
                    nx = chg;
                    if (!ch_zero) begin
                        nx.paused = 1'b1;
                        acc       = 1'b1;
                    end
                end
            end
            CMD_RESUME:
            begin
                if (cfg.enabled && st.started && st.paused && !st.flag) begin
                    nx.paused = 1'b0;
                    nx.anchor = req.now_ms;
                    acc       = 1'b1;
                end
            end
            CMD_UPDATE:
            begin
                nx  = chg;
                acc = cfg.enabled;
            end
            CMD_MOVE:
            begin
                if (!cfg.enabled) begin
                    mst = MS_DISABLED;
                end else if (!st.started) begin
                    mst = MS_NOT_STARTED;
                end else if (st.flag) begin
                    mst = MS_FLAGGED;
                end else if (st.paused) begin
                    mst = MS_PAUSED;
                end else if (req.side != st.running_side) begin
                    mst = MS_WRONG_SIDE;
                end else if (ch_zero) begin
                    nx  = chg;
                    mst = MS_FLAGGED;
                end else begin
                    nx                     = chg;
                    nx.side_time[req.side] = sat_add(ch_rem, cfg.increment_ms);
                    nx.running_side        = ~req.side;
                    nx.anchor              = req.now_ms;
                    acc                    = 1'b1;
                end
            end
            CMD_SET_ONE:
            begin
                if (cfg.enabled) begin
                    nx                     = chg;
                    nx.side_time[req.side] = req.value_a;
                    nx                     = reconcile(nx, req.now_ms);
                    acc                    = 1'b1;
                end
            end
            CMD_SYNC_BOTH:
            begin
                if (cfg.enabled) begin
                    nx              = chg;
                    nx.side_time[0] = req.value_a;
                    nx.side_time[1] = req.value_b;
                    nx              = reconcile(nx, req.now_ms);
                    acc             = 1'b1;
                end
            end
            CMD_ADD_TIME:
            begin
                if (add_ok) begin
                    nx = chg;
                    if (!(running && ch_zero)) begin
                        nx.side_time[req.side] = sat_add(chg.side_time[req.side],
                                                         req.value_a);
                        nx.event_seen          = 1'b1;
                        nx.event_last          = req.event_id;
                        nx.anchor              = req.now_ms;
                        acc                    = 1'b1;
                    end
                end
            end
            CMD_QUERY:
            begin
                acc = cfg.enabled;
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase

        // Project the running side to now. An anchor at now means no time has
        // passed; otherwise the state is untouched and the charge above holds.
        run_n   = cfg.enabled && nx.started && !nx.paused && !nx.flag;
        proj_rs = (nx.anchor == req.now_ms) ? nx.side_time[nx.running_side]
                                            : (ch_zero ? '0 : ch_rem);

        res.accepted    = acc;
        res.move_status = mst;
        res.white_ms    = (run_n && !nx.running_side) ? proj_rs : nx.side_time[0];
        res.black_ms    = (run_n &&  nx.running_side) ? proj_rs : nx.side_time[1];
        res.active_side = nx.running_side;
        res.is_started  = nx.started;
        res.is_paused   = nx.paused;
        res.has_flag    = nx.flag;
        res.flag_side   = nx.flag_who;
        res.has_event   = nx.event_seen;
        res.last_event  = nx.event_last;
        if (!nx.flag && run_n && (proj_rs == '0)) begin
            res.has_flag  = 1'b1;
            res.flag_side = nx.running_side;
            res.is_paused = 1'b0;
        end
    end

endmodule

>>> design/two_side_increment_countdown_clock.sv
// Two-sided countdown clock with a per-move increment.
//
// Requests enter on in_valid/in_stall with a command, a side, a wrapping
// millisecond timestamp and up to three operands. Every request yields one
// result on out_valid/out_stall: an accepted bit, a move status and a full
// snapshot of both sides projected to the request's timestamp.
// A request is held in the input register, is resolved in a single
// pass of logic against the live clock state, and lands in the result
// register; out_valid rises once the result register is loaded. One
// request per cycle is taken at full rate while out_stall is low; the
// only loop is the state register feeding back into the single-pass update.
// When the receiver stalls, the result is held and the request behind it waits
// in the input register; in_stall rises only while both stages are occupied.
// The APB port sets enable, initial time and increment; write it only while
// no request is in flight. Reset clears the configuration, leaves both sides
// at zero time, unstarted, white to move, and empties both stages.
`include "assert_macros.svh"

module two_side_increment_countdown_clock (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tsicc_pkg::CMD_W-1:0]     cmd,
    input  logic                            side,
    input  logic [tsicc_pkg::TIME_W-1:0]    now_ms,
    input  logic [tsicc_pkg::TIME_W-1:0]    value_a,
    input  logic [tsicc_pkg::TIME_W-1:0]    value_b,
    input  logic [tsicc_pkg::TIME_W-1:0]    event_id,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    output logic [tsicc_pkg::MST_W-1:0]     move_status,
    output logic [tsicc_pkg::TIME_W-1:0]    white_ms,
    output logic [tsicc_pkg::TIME_W-1:0]    black_ms,
    output logic                            active_side,
    output logic                            is_started,
    output logic                            is_paused,
    output logic                            has_flag,
    output logic                            flag_side,
    output logic                            has_event,
    output logic [tsicc_pkg::TIME_W-1:0]    last_event,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsicc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tsicc_pkg::PDATA_W-1:0]   pwdata,
    output logic [tsicc_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import tsicc_pkg::*;

    tsicc_cfg_t    cfg_reg;
    tsicc_state_t  state_reg;
    tsicc_state_t  state_next;
    tsicc_req_t    req_reg;
    logic          in_valid_reg;
    tsicc_result_t res_reg;
    tsicc_result_t res_next;
    logic          out_valid_reg;
    logic          in_take;
    logic          fire;
    logic          cfg_wr;
    reg_idx_t      cfg_idx;

    // Resolve the held request whenever the result register is free or drains.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    tsicc_step u_step (
        .cfg (cfg_reg),
        .st  (state_reg),
        .req (req_reg),
        .nx  (state_next),
        .res (res_next)
    );

    // Input register: hold the request until it is resolved.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            req_reg.cmd      <= cmd_t'(cmd);
            req_reg.side     <= side;
            req_reg.now_ms   <= now_ms;
            req_reg.value_a  <= value_a;
            req_reg.value_b  <= value_b;
            req_reg.event_id <= event_id;
        end
    end

    // Clock state: advance once per resolved request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= new_game_state('0);
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Result register: load on resolve, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = res_reg.accepted;
    assign move_status = res_reg.move_status;
    assign white_ms    = res_reg.white_ms;
    assign black_ms    = res_reg.black_ms;
    assign active_side = res_reg.active_side;
    assign is_started  = res_reg.is_started;
    assign is_paused   = res_reg.is_paused;
    assign has_flag    = res_reg.has_flag;
    assign flag_side   = res_reg.flag_side;
    assign has_event   = res_reg.has_event;
    assign last_event  = res_reg.last_event;

    // Configuration registers, one word apart.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.enabled      <= 1'b0;
            cfg_reg.initial_ms   <= '0;
            cfg_reg.increment_ms <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE:    cfg_reg.enabled      <= pwdata[0];
                REG_INITIAL:   cfg_reg.initial_ms   <= pwdata[TIME_W-1:0];
                REG_INCREMENT: cfg_reg.increment_ms <= pwdata[TIME_W-1:0];
                default:       cfg_reg.enabled      <= cfg_reg.enabled;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:    prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.enabled};
            REG_INITIAL:   prdata = cfg_reg.initial_ms;
            REG_INCREMENT: prdata = cfg_reg.increment_ms;
            default:       prdata = '0;
        endcase
    end

    // A fallen flag always clears the pause.
    `ASSERT_IMP(a_flag_unpaused, clk, rst_n, state_reg.flag, !state_reg.paused)
    // Only a started clock can be paused.
    `ASSERT_IMP(a_pause_needs_start, clk, rst_n, state_reg.paused, state_reg.started)
    // A refused move never reports accepted.
    `ASSERT_IMP(a_move_status_acc, clk, rst_n, out_valid_reg && res_reg.accepted,
                res_reg.move_status == MS_APPLIED)
    // Snapshot never shows flagged and paused together.
    `ASSERT_IMP(a_snap_flag_pause, clk, rst_n, out_valid_reg && res_reg.has_flag,
                !res_reg.is_paused)
    // Without a resolved request, the clock state holds its value.
    `ASSERT_NXT(a_state_hold, clk, rst_n, !fire, state_reg == $past(state_reg))

endmodule
